// ===== rtl/core/jlvr_pkg.sv =====
// shared constants, types and helpers of the jerk limited velocity ramp
package jlvr_pkg;

    localparam int NUM_FIELDS = 4;
    localparam int AXES       = 4;
    localparam int VW         = 32;
    localparam int LIM_W      = 31;
    localparam int TICK_W     = 24;
    localparam int JMAG_W     = 47;
    localparam int KW         = 2;

    localparam int MUL_W      = 64;
    localparam int DIV_NUM_W  = 96;
    localparam int DIV_DEN_W  = 64;
    localparam int CNT_W      = 7;
    localparam int MUL_STEPS  = MUL_W;
    localparam int DIV_STEPS  = DIV_NUM_W;

    localparam logic [KW-1:0]     AXIS_LAST   = KW'(AXES - 1);
    localparam logic [31:0]       TIME_MAX    = 32'hFFFF_FFFE;
    localparam logic [63:0]       JERK_SAT    = (64'd1 << 47) - 64'd1;
    localparam logic [63:0]       RAMP_SAT    = 64'd1 << 34;
    localparam logic [LIM_W-1:0]  ACCEL_RST   = LIM_W'(6553600);
    localparam logic [LIM_W-1:0]  JERK_RST    = LIM_W'(19660800);
    localparam logic [TICK_W-1:0] TICK_RST    = TICK_W'(16777);

    typedef enum logic [1:0] {
        CFG_ACCEL = 2'd0,
        CFG_JERK  = 2'd1,
        CFG_TICK  = 2'd2
    } t_cfg_index;

    // clamp a time value to the largest usable time
    function automatic logic [31:0] cap_time(input logic [63:0] t);
        if (t > {32'd0, TIME_MAX}) begin
            return TIME_MAX;
        end
        return t[31:0];
    endfunction

endpackage

// ===== rtl/core/jerk_limited_velocity_ramp.sv =====
// top level: s-curve velocity ramp sequencer around a serial multiplier and divider
//
// One request on the input stream is one control tick: start and target velocity of each
// axis, signed Q16.16. Each tick returns one result with the commanded velocity of every
// axis and tlast raised on the tick that ends a move. Work is one item at a time and runs
// through a shared bit-serial multiplier and a shared restoring divider. A ramp tick
// takes 2 or 3 multiplies for the time factor and one per axis. The first tick of a
// move also plans: a peak search over the axes, two divides, one multiply and one
// divide per axis (no divide when the ramp time is zero). The tick that ends a move
// hands out the targets with no multiply or divide. A new request is taken while the
// previous result still waits in the output register. Configuration writes are always
// ready; the user must write the limits between moves only, and the block itself does
// not enforce this.
module jerk_limited_velocity_ramp (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // input stream, tdata lowest bits up: start_vel_a0..a3, target_vel_a0..a3
    input  logic                        s_axis_tvalid,
    output logic                        s_axis_tready,
    input  logic [8*jlvr_pkg::VW-1:0]   s_axis_tdata,
    // output stream, tdata lowest bits up: vel_cmd_a0..a3; tlast is finished
    output logic                        m_axis_tvalid,
    input  logic                        m_axis_tready,
    output logic [4*jlvr_pkg::VW-1:0]   m_axis_tdata,
    output logic                        m_axis_tlast,
    // register write channel
    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  logic [1:0]                  i_cfg_index,
    input  logic [jlvr_pkg::LIM_W-1:0]  i_cfg_data
);
    import jlvr_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE, S_PEAK, S_TA_GO, S_TA_WT, S_TB_GO, S_TB_WT, S_TIMES,
        S_DEN_GO, S_DEN_WT, S_JK_GO, S_JK_WT, S_CHK, S_H1_GO, S_H1_WT,
        S_F_GO, S_F_WT, S_H2_GO, S_H2_WT, S_RMP_GO, S_RMP_WT, S_ADV, S_OUT
    } t_state;

    t_state r_state;

    // configuration
    logic [LIM_W-1:0]  r_accel;
    logic [LIM_W-1:0]  r_jerk;
    logic [TICK_W-1:0] r_tick;

    // move state
    logic [31:0] r_elapsed;
    logic [31:0] r_peak;
    logic [31:0] r_ta;
    logic [31:0] r_tb;
    logic [31:0] r_t2;
    logic [31:0] r_t3;
    logic [63:0] r_den;
    logic [62:0] r_h1;
    logic [63:0] r_f;
    logic [JMAG_W-1:0] r_jmag [NUM_FIELDS];
    logic              r_jneg [NUM_FIELDS];

    // tick payload and results
    logic [VW-1:0] r_sv  [NUM_FIELDS];
    logic [VW-1:0] r_tv  [NUM_FIELDS];
    logic [VW-1:0] r_vel [NUM_FIELDS];
    logic          r_last;
    logic [KW-1:0] r_k;

    logic                 r_m_tvalid;
    logic [4*VW-1:0]      r_m_tdata;
    logic                 r_m_tlast;

    // shared units
    logic                 n_mul_start;
    logic [MUL_W-1:0]     n_mul_a;
    logic [MUL_W-1:0]     n_mul_b;
    logic                 mul_done;
    logic [2*MUL_W-1:0]   mul_prod;
    logic                 n_div_start;
    logic [DIV_NUM_W-1:0] n_div_num;
    logic [DIV_DEN_W-1:0] n_div_den;
    logic                 div_done;
    logic [DIV_DEN_W-1:0] div_quo;
    logic                 div_ovf;

    // per-axis difference and helpers
    logic [VW:0]       n_diff;
    logic              n_neg;
    logic [31:0]       n_mag;
    logic [LIM_W-1:0]  n_accel;
    logic [LIM_W-1:0]  n_jerk;
    logic              n_in_one;
    logic              n_in_two;
    logic [31:0]       n_u;
    logic [63:0]       n_rmag;
    logic [VW+3:0]     n_vsum;
    logic [VW-1:0]     n_vsat;
    logic [63:0]       n_hold;
    logic [32:0]       n_adv;

    assign n_diff  = {r_tv[r_k][VW-1], r_tv[r_k]} - {r_sv[r_k][VW-1], r_sv[r_k]};
    assign n_neg   = n_diff[VW];
    assign n_mag   = n_neg ? 32'(-n_diff) : n_diff[31:0];
    // a limit of zero behaves as one
    assign n_accel = (r_accel == '0) ? LIM_W'(1) : r_accel;
    assign n_jerk  = (r_jerk == '0) ? LIM_W'(1) : r_jerk;
    assign n_in_one = r_elapsed <= r_ta;
    assign n_in_two = r_elapsed <= r_t2;
    assign n_u      = r_elapsed - r_t2;
    assign n_hold   = (div_quo > {32'd0, r_ta}) ? (div_quo - {32'd0, r_ta}) : 64'd0;
    assign n_adv    = {1'b0, r_elapsed} + {9'd0, r_tick};

    // ramp magnitude and saturated velocity of axis r_k
    always_comb begin
        n_rmag = mul_prod[111:48];
        if (n_rmag > RAMP_SAT) begin
            n_rmag = RAMP_SAT;
        end
        if (r_jneg[r_k]) begin
            n_vsum = {{4{r_sv[r_k][VW-1]}}, r_sv[r_k]} - {1'b0, n_rmag[34:0]};
        end else begin
            n_vsum = {{4{r_sv[r_k][VW-1]}}, r_sv[r_k]} + {1'b0, n_rmag[34:0]};
        end
        if ($signed(n_vsum) > $signed({4'd0, 1'b0, {(VW-1){1'b1}}})) begin
            n_vsat = {1'b0, {(VW-1){1'b1}}};
        end else if ($signed(n_vsum) < $signed({4'hF, 1'b1, {(VW-1){1'b0}}})) begin
            n_vsat = {1'b1, {(VW-1){1'b0}}};
        end else begin
            n_vsat = n_vsum[VW-1:0];
        end
    end

    // operand selection for the shared units
    always_comb begin
        n_mul_start = 1'b0;
        n_mul_a     = '0;
        n_mul_b     = '0;
        n_div_start = 1'b0;
        n_div_num   = '0;
        n_div_den   = '0;
        case (r_state)
            S_TA_GO: begin
                n_div_start = 1'b1;
                n_div_num   = {41'd0, n_accel, 24'd0};
                n_div_den   = {33'd0, n_jerk};
            end
            S_TB_GO: begin
                n_div_start = 1'b1;
                n_div_num   = {40'd0, r_peak, 24'd0};
                n_div_den   = {33'd0, n_accel};
            end
            S_JK_GO: begin
                n_div_start = r_den != '0;
                n_div_num   = {16'd0, n_mag, 48'd0};
                n_div_den   = r_den;
            end
            S_DEN_GO: begin
                n_mul_start = 1'b1;
                n_mul_a     = {32'd0, r_ta};
                n_mul_b     = {32'd0, r_t2};
            end
            S_H1_GO: begin
                n_mul_start = 1'b1;
                n_mul_a     = {32'd0, r_ta};
                n_mul_b     = {32'd0, r_ta};
            end
            S_F_GO: begin
                n_mul_start = 1'b1;
                if (n_in_one) begin
                    n_mul_a = {32'd0, r_elapsed};
                    n_mul_b = {32'd0, r_elapsed};
                end else if (n_in_two) begin
                    n_mul_a = {32'd0, r_ta};
                    n_mul_b = {32'd0, r_elapsed - r_ta};
                end else begin
                    // t1*t2 + t1*u folds into t1*t
                    n_mul_a = {32'd0, r_ta};
                    n_mul_b = {32'd0, r_elapsed};
                end
            end
            S_H2_GO: begin
                n_mul_start = 1'b1;
                n_mul_a     = {32'd0, n_u};
                n_mul_b     = {32'd0, n_u};
            end
            S_RMP_GO: begin
                n_mul_start = 1'b1;
                n_mul_a     = r_f;
                n_mul_b     = {17'd0, r_jmag[r_k]};
            end
            default: begin
            end
        endcase
    end

    jlvr_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (n_mul_start),
        .i_a     (n_mul_a),
        .i_b     (n_mul_b),
        .o_done  (mul_done),
        .o_prod  (mul_prod)
    );

    jlvr_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (n_div_start),
        .i_num   (n_div_num),
        .i_den   (n_div_den),
        .o_done  (div_done),
        .o_quo   (div_quo),
        .o_ovf   (div_ovf)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_accel    <= ACCEL_RST;
            r_jerk     <= JERK_RST;
            r_tick     <= TICK_RST;
            r_elapsed  <= '0;
            r_peak     <= '0;
            r_ta       <= '0;
            r_tb       <= '0;
            r_t2       <= '0;
            r_t3       <= '0;
            r_k        <= '0;
            r_m_tvalid <= 1'b0;
        end else begin
            // register writes
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    CFG_ACCEL: r_accel <= i_cfg_data;
                    CFG_JERK:  r_jerk  <= i_cfg_data;
                    CFG_TICK:  r_tick  <= i_cfg_data[TICK_W-1:0];
                    default: begin
                    end
                endcase
            end

            // S_OUT reloads the output register itself
            if (r_m_tvalid && m_axis_tready && r_state != S_OUT) begin
                r_m_tvalid <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (s_axis_tvalid) begin
                        for (int i = 0; i < NUM_FIELDS; i++) begin
                            r_sv[i] <= s_axis_tdata[i*VW +: VW];
                            r_tv[i] <= s_axis_tdata[(NUM_FIELDS+i)*VW +: VW];
                        end
                        r_k     <= '0;
                        r_state <= (r_elapsed == '0) ? S_PEAK : S_CHK;
                    end
                end
                // largest velocity change, one axis a cycle
                S_PEAK: begin
                    if (n_mag > r_peak) begin
                        r_peak <= n_mag;
                    end
                    if (r_k == AXIS_LAST) begin
                        r_state <= S_TA_GO;
                    end else begin
                        r_k <= r_k + KW'(1);
                    end
                end
                S_TA_GO: r_state <= S_TA_WT;
                S_TA_WT: begin
                    if (div_done) begin
                        r_ta    <= cap_time(div_quo);
                        r_state <= S_TB_GO;
                    end
                end
                S_TB_GO: r_state <= S_TB_WT;
                S_TB_WT: begin
                    if (div_done) begin
                        r_tb    <= cap_time(n_hold);
                        r_state <= S_TIMES;
                    end
                end
                S_TIMES: begin
                    r_t2    <= cap_time({32'd0, r_ta} + {32'd0, r_tb});
                    r_t3    <= cap_time({31'd0, r_ta, 1'b0} + {32'd0, r_tb});
                    r_state <= S_DEN_GO;
                end
                S_DEN_GO: r_state <= S_DEN_WT;
                S_DEN_WT: begin
                    if (mul_done) begin
                        r_den   <= mul_prod[63:0];
                        r_k     <= '0;
                        r_state <= S_JK_GO;
                    end
                end
                // jerk per axis; a zero ramp time gives zero jerk
                S_JK_GO: begin
                    r_jneg[r_k] <= n_neg;
                    if (r_den == '0) begin
                        r_jmag[r_k] <= '0;
                        if (r_k == AXIS_LAST) begin
                            r_state <= S_CHK;
                        end else begin
                            r_k <= r_k + KW'(1);
                        end
                    end else begin
                        r_state <= S_JK_WT;
                    end
                end
                S_JK_WT: begin
                    if (div_done) begin
                        if (div_ovf || div_quo > JERK_SAT) begin
                            r_jmag[r_k] <= JERK_SAT[JMAG_W-1:0];
                        end else begin
                            r_jmag[r_k] <= div_quo[JMAG_W-1:0];
                        end
                        if (r_k == AXIS_LAST) begin
                            r_state <= S_CHK;
                        end else begin
                            r_k     <= r_k + KW'(1);
                            r_state <= S_JK_GO;
                        end
                    end
                end
                S_CHK: begin
                    if (r_elapsed <= r_t3) begin
                        r_state <= S_H1_GO;
                    end else begin
                        // move done: hand out the targets and rearm
                        for (int i = 0; i < NUM_FIELDS; i++) begin
                            r_vel[i] <= r_tv[i];
                        end
                        r_last    <= 1'b1;
                        r_elapsed <= '0;
                        r_peak    <= '0;
                        r_state   <= S_OUT;
                    end
                end
                S_H1_GO: r_state <= S_H1_WT;
                S_H1_WT: begin
                    if (mul_done) begin
                        r_h1    <= mul_prod[63:1];
                        r_state <= S_F_GO;
                    end
                end
                S_F_GO: r_state <= S_F_WT;
                S_F_WT: begin
                    if (mul_done) begin
                        if (n_in_one) begin
                            r_f     <= {1'b0, mul_prod[63:1]};
                            r_k     <= '0;
                            r_state <= S_RMP_GO;
                        end else if (n_in_two) begin
                            r_f     <= mul_prod[63:0] + {1'b0, r_h1};
                            r_k     <= '0;
                            r_state <= S_RMP_GO;
                        end else begin
                            r_f     <= mul_prod[63:0] - {1'b0, r_h1};
                            r_state <= S_H2_GO;
                        end
                    end
                end
                S_H2_GO: r_state <= S_H2_WT;
                // falling jerk: bleed off u*u/2, floor at zero
                S_H2_WT: begin
                    if (mul_done) begin
                        if (r_f > {1'b0, mul_prod[63:1]}) begin
                            r_f <= r_f - {1'b0, mul_prod[63:1]};
                        end else begin
                            r_f <= '0;
                        end
                        r_k     <= '0;
                        r_state <= S_RMP_GO;
                    end
                end
                S_RMP_GO: r_state <= S_RMP_WT;
                S_RMP_WT: begin
                    if (mul_done) begin
                        r_vel[r_k] <= n_vsat;
                        if (r_k == AXIS_LAST) begin
                            r_state <= S_ADV;
                        end else begin
                            r_k     <= r_k + KW'(1);
                            r_state <= S_RMP_GO;
                        end
                    end
                end
                S_ADV: begin
                    r_elapsed <= n_adv[32] ? 32'hFFFF_FFFF : n_adv[31:0];
                    r_last    <= 1'b0;
                    r_state   <= S_OUT;
                end
                // wait for the output register to free up
                S_OUT: begin
                    if (!r_m_tvalid || m_axis_tready) begin
                        for (int i = 0; i < NUM_FIELDS; i++) begin
                            r_m_tdata[i*VW +: VW] <= (i < AXES) ? r_vel[i] : '0;
                        end
                        r_m_tlast  <= r_last;
                        r_m_tvalid <= 1'b1;
                        r_state    <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign s_axis_tready = r_state == S_IDLE;
    assign m_axis_tvalid = r_m_tvalid;
    assign m_axis_tdata  = r_m_tdata;
    assign m_axis_tlast  = r_m_tlast;
    assign o_cfg_ready   = 1'b1;

endmodule

// ===== rtl/core/jlvr_mul.sv =====
// bit serial shift-add multiplier, one multiplier bit per cycle
module jlvr_mul (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_start,
    input  logic [jlvr_pkg::MUL_W-1:0]     i_a,
    input  logic [jlvr_pkg::MUL_W-1:0]     i_b,
    output logic                           o_done,
    output logic [2*jlvr_pkg::MUL_W-1:0]   o_prod
);
    import jlvr_pkg::*;

    logic [2*MUL_W-1:0] r_acc;
    logic [MUL_W-1:0]   r_a;
    logic [MUL_W-1:0]   r_b;
    logic [CNT_W-1:0]   r_cnt;
    logic               r_busy;
    logic               r_done;
    logic [MUL_W:0]     n_sum;

    assign n_sum = {1'b0, r_acc[2*MUL_W-1:MUL_W]} + (r_b[0] ? {1'b0, r_a} : '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_acc  <= '0;
                r_a    <= i_a;
                r_b    <= i_b;
                r_cnt  <= '0;
                r_busy <= 1'b1;
            end else if (r_busy) begin
                r_acc <= {n_sum, r_acc[MUL_W-1:1]};
                r_b   <= r_b >> 1;
                r_cnt <= r_cnt + CNT_W'(1);
                if (r_cnt == CNT_W'(MUL_STEPS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_prod = r_acc;

endmodule

// ===== rtl/core/jlvr_div.sv =====
// restoring divider, one quotient bit per cycle, sticky flag for lost high bits
module jlvr_div (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_start,
    input  logic [jlvr_pkg::DIV_NUM_W-1:0]   i_num,
    input  logic [jlvr_pkg::DIV_DEN_W-1:0]   i_den,
    output logic                             o_done,
    output logic [jlvr_pkg::DIV_DEN_W-1:0]   o_quo,
    output logic                             o_ovf
);
    import jlvr_pkg::*;

    logic [DIV_NUM_W-1:0] r_num;
    logic [DIV_DEN_W-1:0] r_den;
    logic [DIV_DEN_W-1:0] r_rem;
    logic [DIV_DEN_W-1:0] r_quo;
    logic                 r_ovf;
    logic [CNT_W-1:0]     r_cnt;
    logic                 r_busy;
    logic                 r_done;
    logic [DIV_DEN_W:0]   n_trial;
    logic [DIV_DEN_W:0]   n_diff;
    logic                 n_ge;

    assign n_trial = {r_rem, r_num[DIV_NUM_W-1]};
    assign n_ge    = n_trial >= {1'b0, r_den};
    assign n_diff  = n_trial - {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_num  <= i_num;
                r_den  <= i_den;
                r_rem  <= '0;
                r_quo  <= '0;
                r_ovf  <= 1'b0;
                r_cnt  <= '0;
                r_busy <= 1'b1;
            end else if (r_busy) begin
                r_num <= r_num << 1;
                r_rem <= n_ge ? n_diff[DIV_DEN_W-1:0] : n_trial[DIV_DEN_W-1:0];
                r_quo <= {r_quo[DIV_DEN_W-2:0], n_ge};
                r_ovf <= r_ovf | r_quo[DIV_DEN_W-1];
                r_cnt <= r_cnt + CNT_W'(1);
                if (r_cnt == CNT_W'(DIV_STEPS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_quo;
    assign o_ovf  = r_ovf;

endmodule
